FILE: design/fwt_pkg.sv
// Shared constants, types and codes for the Fenwick tree prefix sum unit.
`default_nettype none

package fwt_pkg;

  // Tree capacity and derived widths.
  localparam int unsigned MaxElements = 1024;
  localparam int unsigned AddrW       = $clog2(MaxElements);
  localparam int unsigned PosW        = 11;
  localparam int unsigned SizeW       = 11;
  localparam int unsigned IdxW        = PosW + 1;
  localparam int unsigned DataW       = 32;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(1024);
  localparam logic [IdxW-1:0]  MaxIdx    = IdxW'(MaxElements);

  // Request codes carried in the req_type field.
  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_BUILD = 2'd2
  } req_type_e;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FOLD,
    ST_DONE
  } state_e;

  // One cycle of memory traffic: an optional write and one read.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: design/fwt_req_if.sv
// Request channel: operation code, position and value.
`default_nettype none

interface fwt_req_if
  import fwt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [PosW-1:0]         position;
  logic signed [DataW-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

`default_nettype wire

FILE: design/fwt_rsp_if.sv
// Response channel: prefix sum and status.
`default_nettype none

interface fwt_rsp_if
  import fwt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] prefix_sum;
  logic                    status;

  modport source (output valid, prefix_sum, status, input ready);
  modport sink   (input valid, prefix_sum, status, output ready);
endinterface

`default_nettype wire

FILE: design/fwt_cfg_if.sv
// Configuration write channel carrying the size in use.
`default_nettype none

interface fwt_cfg_if
  import fwt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SizeW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: design/fenwick_tree_prefix_sum_unit.sv
// Fenwick tree prefix sum unit: accepts add, query and build transactions.
// After reset a clearing pass zeroes all 1024 cells; no request is taken in that
// time, configuration writes are. One request is in flight at a time: it walks
// one tree level per step (one memory read each, with a write for add and build,
// at most 11 levels), and a build that folds into its parent adds a fold step.
// Flagged requests and queries at position 0 skip the walk.
`default_nettype none

module fenwick_tree_prefix_sum_unit
  import fwt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fwt_req_if.sink   req_i,
  fwt_rsp_if.source rsp_o,
  fwt_cfg_if.sink   cfg_i
);

  state_e state_q, state_d;

  logic [SizeW-1:0] size_q;
  logic [AddrW:0]   clr_q, clr_d;

  req_type_e        kind_q, kind_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  n_q, n_d;
  logic [DataW-1:0] val_q, val_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] hold_q, hold_d;
  logic             flag_q, flag_d;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_sum_q, out_sum_d;
  logic             out_flag_q, out_flag_d;

  mem_req_t         mreq;
  logic [DataW-1:0] rdata;

  logic             accept;
  logic             out_free;
  logic [IdxW-1:0]  eff_n;
  logic [IdxW-1:0]  pos_in;
  logic             bad_pos;
  logic             req_flag;
  logic [IdxW-1:0]  low;
  logic [IdxW-1:0]  up;
  logic [IdxW-1:0]  down;
  logic [DataW-1:0] cell_sum;

  fwt_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // Configuration register is always writable.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_i.valid) begin
      size_q <= cfg_i.data;
    end
  end

  // Handshakes and request decode.
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign eff_n   = ({1'b0, size_q} > MaxIdx) ? MaxIdx : {1'b0, size_q};
  assign pos_in  = {1'b0, req_i.position};
  assign bad_pos = (pos_in == '0) || (pos_in > eff_n);

  always_comb begin
    case (req_type_e'(req_i.req_type))
      REQ_ADD, REQ_BUILD: req_flag = bad_pos;
      REQ_QUERY:          req_flag = pos_in > eff_n;
      default:            req_flag = 1'b1;
    endcase
  end

  // Tree index arithmetic on the current cell.
  assign low      = idx_q & (~idx_q + IdxW'(1));
  assign up       = idx_q + low;
  assign down     = idx_q - low;
  assign cell_sum = rdata + val_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q[AddrW-1:0] == AddrW'(MaxElements - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_flag || (req_type_e'(req_i.req_type) == REQ_QUERY && pos_in == '0)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        case (kind_q)
          REQ_ADD:   state_d = (up <= n_q) ? ST_WALK : ST_DONE;
          REQ_QUERY: state_d = (down != '0) ? ST_WALK : ST_DONE;
          REQ_BUILD: state_d = (up <= n_q) ? ST_FOLD : ST_DONE;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_FOLD: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory traffic and datapath updates.
  always_comb begin
    clr_d       = clr_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    n_d         = n_q;
    val_d       = val_q;
    acc_d       = acc_q;
    hold_d      = hold_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_sum_d   = out_sum_q;
    out_flag_d  = out_flag_q;

    mreq.we    = 1'b0;
    mreq.waddr = AddrW'(idx_q - IdxW'(1));
    mreq.wdata = cell_sum;
    mreq.raddr = AddrW'(idx_q - IdxW'(1));

    unique case (state_q)
      ST_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = clr_q[AddrW-1:0];
        mreq.wdata = '0;
        clr_d      = clr_q + (AddrW+1)'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          kind_d     = req_type_e'(req_i.req_type);
          idx_d      = pos_in;
          n_d        = eff_n;
          val_d      = req_i.value;
          acc_d      = '0;
          flag_d     = req_flag;
          mreq.raddr = AddrW'(pos_in - IdxW'(1));
        end
      end
      ST_WALK: begin
        case (kind_q)
          REQ_ADD: begin
            mreq.we    = 1'b1;
            idx_d      = up;
            mreq.raddr = AddrW'(up - IdxW'(1));
          end
          REQ_QUERY: begin
            acc_d      = acc_q + rdata;
            idx_d      = down;
            mreq.raddr = AddrW'(down - IdxW'(1));
          end
          REQ_BUILD: begin
            // Store the new cell and fetch its parent for the fold.
            mreq.we    = 1'b1;
            hold_d     = cell_sum;
            idx_d      = up;
            mreq.raddr = AddrW'(up - IdxW'(1));
          end
          default: begin
            flag_d = 1'b1;
          end
        endcase
      end
      ST_FOLD: begin
        mreq.we    = 1'b1;
        mreq.wdata = rdata + hold_q;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = (kind_q == REQ_QUERY && !flag_q) ? acc_q : '0;
          out_flag_d  = flag_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    idx_q      <= idx_d;
    n_q        <= n_d;
    val_q      <= val_d;
    acc_q      <= acc_d;
    hold_q     <= hold_d;
    flag_q     <= flag_d;
    out_sum_q  <= out_sum_d;
    out_flag_q <= out_flag_d;
  end

  // Response port.
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.prefix_sum = out_sum_q;
  assign rsp_o.status     = out_flag_q;

endmodule

`default_nettype wire

FILE: design/fwt_mem.sv
// Tree cell store: one write port and one registered read port.
`default_nettype none

module fwt_mem
  import fwt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire mem_req_t         req_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [MaxElements];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port: data appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[req_i.raddr];
  end

endmodule

`default_nettype wire
